### sv/mcst_pkg.sv
// ----------------------------------------------------------------------------
// mcst_pkg: shared types and constants
// Register indexes, configuration bundle, request and result payloads.
// ----------------------------------------------------------------------------
package mcst_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int BANK_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PICKUP_WINDOW = 3'd0,
        CFG_BANK_A_BASE   = 3'd1,
        CFG_BANK_B_BASE   = 3'd2,
        CFG_CLEAR_NUMBER  = 3'd3,
        CFG_CYCLE_NUMBER  = 3'd4,
        CFG_TOGGLE_NUMBER = 3'd5
    } cfg_index_t;

    localparam logic [7:0] RST_PICKUP_WINDOW = 8'd5;
    localparam logic [6:0] RST_BANK_A_BASE   = 7'd16;
    localparam logic [6:0] RST_BANK_B_BASE   = 7'd120;
    localparam logic [6:0] RST_CLEAR_NUMBER  = 7'd58;
    localparam logic [6:0] RST_CYCLE_NUMBER  = 7'd61;
    localparam logic [6:0] RST_TOGGLE_NUMBER = 7'd62;

    localparam logic [7:0] LEVEL_OFFSET = 8'd127;
    localparam logic [1:0] MODE_LAST    = 2'd2;

    typedef struct packed {
        logic [7:0] pickup_window;
        logic [6:0] bank_a_base;
        logic [6:0] bank_b_base;
        logic [6:0] clear_number;
        logic [6:0] cycle_number;
        logic [6:0] toggle_number;
    } cfg_t;

    typedef struct packed {
        logic       is_control_change;
        logic [6:0] controller_number;
        logic [6:0] controller_value;
    } msg_t;

    typedef struct packed {
        logic              touched;
        logic [SLOT_W-1:0] slot_index;
        logic signed [7:0] slot_level;
        logic              slot_picked_up;
        logic [1:0]        pattern_mode;
        logic              wide_crop;
        logic signed [7:0] x_displace;
        logic signed [7:0] y_displace;
    } result_t;

endpackage

### sv/mcst_ifs.sv
// ----------------------------------------------------------------------------
// mcst_ifs: request channel interfaces
// Valid/ready channels for incoming MIDI messages and outgoing results.
// ----------------------------------------------------------------------------
interface mcst_msg_if;
    logic       valid;
    logic       ready;
    logic       is_control_change;
    logic [6:0] controller_number;
    logic [6:0] controller_value;

    modport source (
        output valid, is_control_change, controller_number, controller_value,
        input  ready
    );
    modport sink (
        input  valid, is_control_change, controller_number, controller_value,
        output ready
    );
endinterface

interface mcst_res_if;
    logic              valid;
    logic              ready;
    logic              touched;
    logic [3:0]        slot_index;
    logic signed [7:0] slot_level;
    logic              slot_picked_up;
    logic [1:0]        pattern_mode;
    logic              wide_crop;
    logic signed [7:0] x_displace;
    logic signed [7:0] y_displace;

    modport source (
        output valid, touched, slot_index, slot_level, slot_picked_up,
               pattern_mode, wide_crop, x_displace, y_displace,
        input  ready
    );
    modport sink (
        input  valid, touched, slot_index, slot_level, slot_picked_up,
               pattern_mode, wide_crop, x_displace, y_displace,
        output ready
    );
endinterface

### sv/mcst_cfg_regs.sv
// ----------------------------------------------------------------------------
// mcst_cfg_regs: configuration register file
// Write-only registers addressed by index, reset to their defaults.
// ----------------------------------------------------------------------------
module mcst_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [mcst_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [mcst_pkg::CFG_DATA_W-1:0] wr_data,
    output mcst_pkg::cfg_t                  cfg
);
    import mcst_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_PICKUP_WINDOW: cfg_next.pickup_window = wr_data;
                CFG_BANK_A_BASE:   cfg_next.bank_a_base   = wr_data[6:0];
                CFG_BANK_B_BASE:   cfg_next.bank_b_base   = wr_data[6:0];
                CFG_CLEAR_NUMBER:  cfg_next.clear_number  = wr_data[6:0];
                CFG_CYCLE_NUMBER:  cfg_next.cycle_number  = wr_data[6:0];
                CFG_TOGGLE_NUMBER: cfg_next.toggle_number = wr_data[6:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pickup_window <= RST_PICKUP_WINDOW;
            cfg_reg.bank_a_base   <= RST_BANK_A_BASE;
            cfg_reg.bank_b_base   <= RST_BANK_B_BASE;
            cfg_reg.clear_number  <= RST_CLEAR_NUMBER;
            cfg_reg.cycle_number  <= RST_CYCLE_NUMBER;
            cfg_reg.toggle_number <= RST_TOGGLE_NUMBER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/mcst_engine.sv
// ----------------------------------------------------------------------------
// mcst_engine: slot state and soft-takeover update
// Decodes one message, updates slots, mode, crop and x/y latches.
// ----------------------------------------------------------------------------
module mcst_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mcst_pkg::msg_t    msg_item,
    input  mcst_pkg::cfg_t    cfg,
    output mcst_pkg::result_t res_item
);
    import mcst_pkg::*;

    logic [NUM_SLOTS-1:0][7:0] levels_reg;
    logic [NUM_SLOTS-1:0][7:0] levels_next;
    logic [NUM_SLOTS-1:0]      flags_reg;
    logic [NUM_SLOTS-1:0]      flags_next;
    logic [1:0]                mode_reg;
    logic [1:0]                mode_next;
    logic                      crop_reg;
    logic                      crop_next;
    logic [7:0]                x_reg;
    logic [7:0]                x_next;
    logic [7:0]                y_reg;
    logic [7:0]                y_next;

    logic [7:0]        off_a;
    logic [7:0]        off_b;
    logic              hit_a;
    logic              hit_b;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        level;
    logic [8:0]        diff;
    logic [8:0]        mag;
    logic              near;
    logic              is_clear;
    logic              is_cycle;
    logic              is_toggle;

    // bank offset: sign bit clear and difference below eight
    assign off_a = {1'b0, msg_item.controller_number} - {1'b0, cfg.bank_a_base};
    assign off_b = {1'b0, msg_item.controller_number} - {1'b0, cfg.bank_b_base};
    assign hit_a = msg_item.is_control_change && !off_a[7] && (off_a[6:BANK_W] == '0);
    assign hit_b = msg_item.is_control_change && !off_b[7] && (off_b[6:BANK_W] == '0);
    assign hit   = hit_a || hit_b;
    assign slot  = hit_a ? {1'b0, off_a[BANK_W-1:0]} : {1'b1, off_b[BANK_W-1:0]};

    assign level = {msg_item.controller_value, 1'b0} - LEVEL_OFFSET;
    assign diff  = {level[7], level} - {levels_reg[slot][7], levels_reg[slot]};
    assign mag   = diff[8] ? (9'd0 - diff) : diff;
    assign near  = mag <= {1'b0, cfg.pickup_window};

    assign is_clear  = msg_item.is_control_change
                       && (msg_item.controller_number == cfg.clear_number);
    assign is_cycle  = msg_item.is_control_change
                       && (msg_item.controller_number == cfg.cycle_number);
    assign is_toggle = msg_item.is_control_change
                       && (msg_item.controller_number == cfg.toggle_number);

    always_comb
    begin
        levels_next = levels_reg;
        flags_next  = flags_reg;
        mode_next   = mode_reg;
        crop_next   = crop_reg;
        if (hit)
        begin
            if (near)
            begin
                flags_next[slot] = 1'b1;
            end
            if (flags_next[slot])
            begin
                levels_next[slot] = level;
            end
        end
        if (is_clear)
        begin
            levels_next = '0;
            flags_next  = '0;
        end
        if (is_cycle)
        begin
            mode_next = (mode_reg >= MODE_LAST) ? 2'd0 : mode_reg + 2'd1;
        end
        if (is_toggle)
        begin
            crop_next = !crop_reg;
        end
        x_next = flags_next[0] ? levels_next[0] : x_reg;
        y_next = flags_next[NUM_SLOTS/2] ? levels_next[NUM_SLOTS/2] : y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
            flags_reg  <= '0;
            mode_reg   <= '0;
            crop_reg   <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
        end
        else if (step)
        begin
            levels_reg <= levels_next;
            flags_reg  <= flags_next;
            mode_reg   <= mode_next;
            crop_reg   <= crop_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
        end
    end

    always_comb
    begin
        res_item.touched        = hit;
        res_item.slot_index     = hit ? slot : '0;
        res_item.slot_level     = hit ? levels_next[slot] : '0;
        res_item.slot_picked_up = hit && flags_next[slot];
        res_item.pattern_mode   = mode_next;
        res_item.wide_crop      = crop_next;
        res_item.x_displace     = x_next;
        res_item.y_displace     = y_next;
    end

`ifndef SYNTH
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_clear |=> (flags_reg == '0) && (levels_reg == '0))
        else $error("clear left a slot set");
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'd3)
        else $error("mode out of range");
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(flags_reg) && $stable(levels_reg) && $stable(mode_reg)
                  && $stable(crop_reg) && $stable(x_reg) && $stable(y_reg))
        else $error("state moved without a request");
    a_x_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[0] |-> x_reg == levels_reg[0])
        else $error("x latch out of step with slot 0");
`endif

endmodule

### sv/midi_cc_soft_takeover_top.sv
// ----------------------------------------------------------------------------
// midi_cc_soft_takeover_top: MIDI control-change soft takeover
// Maps control-change requests onto sixteen signed slots with pickup.
// ----------------------------------------------------------------------------
// Usage:
//   msg    : valid/ready request channel, one MIDI message per request.
//   result : valid/ready channel, exactly one result per message.
//   wr_*   : register writes (index, data), taken at any edge with wr_en;
//            write only while no message is in flight.
// Path: an accepted message passes through the input register, then
//   the result register, before its result is valid.
// Throughput: one message per cycle unless the result is held; the slot
//   update is a single compare and write between the input and result registers.
// Reset: registers return to defaults, all slots cleared and not picked
//   up, mode, crop and x/y latches zero; both channels empty.
// Stall: while the result is held, the input register still takes one
//   message; further messages wait on msg.ready.
// ----------------------------------------------------------------------------
module midi_cc_soft_takeover_top (
    input  logic                            clk,
    input  logic                            rst_n,
    mcst_msg_if.sink                        msg,
    mcst_res_if.source                      result,
    input  logic                            wr_en,
    input  logic [mcst_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [mcst_pkg::CFG_DATA_W-1:0] wr_data
);
    import mcst_pkg::*;

    cfg_t    cfg;
    msg_t    in_item_reg;
    logic    in_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    advance;
    logic    step;

    mcst_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    mcst_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .msg_item (in_item_reg),
        .cfg      (cfg),
        .res_item (res_next)
    );

    assign advance   = !res_valid_reg || result.ready;
    assign step      = in_valid_reg && advance;
    assign msg.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (msg.ready)
            begin
                in_valid_reg <= msg.valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            in_item_reg.is_control_change <= msg.is_control_change;
            in_item_reg.controller_number <= msg.controller_number;
            in_item_reg.controller_value  <= msg.controller_value;
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.touched        = res_reg.touched;
    assign result.slot_index     = res_reg.slot_index;
    assign result.slot_level     = res_reg.slot_level;
    assign result.slot_picked_up = res_reg.slot_picked_up;
    assign result.pattern_mode   = res_reg.pattern_mode;
    assign result.wide_crop      = res_reg.wide_crop;
    assign result.x_displace     = res_reg.x_displace;
    assign result.y_displace     = res_reg.y_displace;

`ifndef SYNTH
    a_untouched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.touched |->
            (res_reg.slot_index == '0) && (res_reg.slot_level == '0)
            && !res_reg.slot_picked_up)
        else $error("untouched result carries slot data");
    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res_valid_reg)
        else $error("processed request produced no result");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("pending request dropped");
`endif

endmodule
